[rtl/bpa_pkg.sv]
package bpa_pkg;

   localparam int MAX_PAGES   = 65536;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int MAP_DEPTH   = (MAX_PAGES + 7) / 8;
   localparam int MAP_AW      = $clog2(MAP_DEPTH);
   localparam int PTR_W       = MAP_AW + 1;
   localparam int CNT_W       = $clog2(MAX_PAGES) + 1;
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 33;
   localparam int PG_W        = ADDR_W - PAGE_SHIFT;
   localparam int END_W       = LEN_W + 2 - PAGE_SHIFT;
   localparam int ACT_W       = 2;
   localparam int STAT_W      = 3;
   localparam int REQ_DATA_W  = ((ADDR_W + LEN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((ADDR_W + CNT_W + 7) / 8) * 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_ALLOC     = 2'd0,
      ACT_FREE      = 2'd1,
      ACT_MARK_USED = 2'd2,
      ACT_MARK_FREE = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_OUT_OF_MEM   = 3'd1,
      STAT_IGNORED      = 3'd2,
      STAT_UNALIGNED    = 3'd3,
      STAT_OUT_OF_RANGE = 3'd4,
      STAT_DOUBLE_FREE  = 3'd5,
      STAT_NONE_FOUND   = 3'd6
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;   // capture request word
      logic setup;   // checks, walk bounds
      logic walk;    // map read/modify/write pass
      logic clear;   // post-reset fill of the map
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic walk_done;
   } dp_stat_type;

endpackage

[rtl/bpa_ctrl.sv]
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SETUP = 5'b00100,
      S_WALK  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (stat.clear_last) state_in = S_IDLE;
         S_IDLE:  if (req_tvalid) state_in = S_SETUP;
         S_SETUP: state_in = S_WALK;
         S_WALK:  if (stat.walk_done) state_in = S_RESP;
         S_RESP:  if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

   assign cmd.latch = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.setup = (state_ff == S_SETUP);
   assign cmd.walk  = (state_ff == S_WALK);
   assign cmd.clear = (state_ff == S_CLEAR);

endmodule

[rtl/bpa_dpath.sv]
module bpa_dpath
   import bpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [ACT_W-1:0]  action,
   input  logic [ADDR_W-1:0] address,
   input  logic [LEN_W-1:0]  range_bytes,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   output logic [STAT_W-1:0] status,
   output logic [ADDR_W-1:0] page_address,
   output logic [CNT_W-1:0]  free_total
);

   function automatic logic [3:0] popcnt8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) n = n + 4'(v[i]);
      return n;
   endfunction

   // page map, one bit per page, 1 = used
   logic [7:0] map_mem [MAP_DEPTH];
   logic [7:0] map_rd_ff;

   logic [CNT_W-1:0]  managed_ff, managed_in;
   logic [CNT_W-1:0]  free_cnt_ff, free_cnt_in;
   action_type        act_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [END_W-1:0]  end_pg_ff;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  limit_ff, limit_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [MAP_AW-1:0] rd_idx_ff, rd_idx_in;
   logic              stop_ff, stop_in;
   status_type        stat_ff, stat_in;
   logic [ADDR_W-1:0] pg_addr_ff, pg_addr_in;

   logic [CNT_W-1:0]  total;
   logic [PG_W-1:0]   pg_of_addr;
   logic [CNT_W-1:0]  end_clip;
   logic [CNT_W:0]    nbytes_raw;
   logic [7:0]        in_mask;
   logic [7:0]        avail;
   logic [7:0]        chg;
   logic [3:0]        chg_n;
   logic [2:0]        low_k;
   logic              issue;
   logic              wr_en;
   logic [MAP_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [CNT_W-1:0]  pg_k;

   assign total      = (managed_ff > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : managed_ff;
   assign pg_of_addr = addr_ff[ADDR_W-1:PAGE_SHIFT];
   assign end_clip   = (end_pg_ff > END_W'(total)) ? total : end_pg_ff[CNT_W-1:0];
   assign nbytes_raw = {1'b0, total} + (CNT_W+1)'(7);

   // pages of the byte in flight that the current action touches
   always_comb begin
      in_mask = '0;
      pg_k    = '0;
      for (int k = 0; k < 8; k++) begin
         pg_k       = CNT_W'({rd_idx_ff, 3'(k)});
         in_mask[k] = (pg_k >= lo_ff) && (pg_k < hi_ff);
      end
   end

   assign avail = ~map_rd_ff & in_mask;

   always_comb begin
      low_k = '0;
      for (int k = 7; k >= 0; k--) begin
         if (avail[k]) low_k = 3'(k);
      end
   end

   assign chg   = (act_ff == ACT_MARK_USED) ? avail : (map_rd_ff & in_mask);
   assign chg_n = popcnt8(chg);

   assign issue = cmd.walk && !stop_ff && (ptr_ff < limit_ff);

   always_comb begin
      managed_in  = managed_ff;
      free_cnt_in = free_cnt_ff;
      ptr_in      = ptr_ff;
      limit_in    = limit_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      stop_in     = stop_ff;
      stat_in     = stat_ff;
      pg_addr_in  = pg_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = map_rd_ff;

      if (csr_wr_en) managed_in = csr_wr_data;

      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff[MAP_AW-1:0];
         wr_data = 8'hFF;
         ptr_in  = ptr_ff + PTR_W'(1);
      end

      if (cmd.setup) begin
         stop_in    = 1'b0;
         pg_addr_in = '0;
         ptr_in     = '0;
         limit_in   = '0;
         lo_in      = '0;
         hi_in      = '0;
         case (act_ff)
            ACT_ALLOC: begin
               if (free_cnt_ff == '0) begin
                  stat_in = STAT_OUT_OF_MEM;
               end else begin
                  stat_in  = STAT_NONE_FOUND;
                  limit_in = nbytes_raw[PTR_W+2:3];
                  hi_in    = total;
               end
            end
            ACT_FREE: begin
               if (addr_ff == '0 || addr_ff == '1) begin
                  stat_in = STAT_IGNORED;
               end else if (addr_ff[PAGE_SHIFT-1:0] != '0) begin
                  stat_in = STAT_UNALIGNED;
               end else if (pg_of_addr >= PG_W'(total)) begin
                  stat_in = STAT_OUT_OF_RANGE;
               end else begin
                  stat_in  = STAT_OK;
                  ptr_in   = PTR_W'(pg_of_addr[CNT_W-1:3]);
                  limit_in = PTR_W'(pg_of_addr[CNT_W-1:3]) + PTR_W'(1);
                  lo_in    = pg_of_addr[CNT_W-1:0];
                  hi_in    = pg_of_addr[CNT_W-1:0] + CNT_W'(1);
               end
            end
            default: begin
               stat_in = STAT_OK;
               if (pg_of_addr < PG_W'(end_clip)) begin
                  ptr_in   = PTR_W'(pg_of_addr[CNT_W-1:3]);
                  limit_in = PTR_W'((end_clip + CNT_W'(7)) >> 3);
                  lo_in    = pg_of_addr[CNT_W-1:0];
                  hi_in    = end_clip;
               end
            end
         endcase
      end

      if (issue) begin
         rd_vld_in = 1'b1;
         rd_idx_in = ptr_ff[MAP_AW-1:0];
         ptr_in    = ptr_ff + PTR_W'(1);
      end

      if (cmd.walk && rd_vld_ff && !stop_ff) begin
         case (act_ff)
            ACT_ALLOC: begin
               if (avail != '0) begin
                  wr_en       = 1'b1;
                  wr_data     = map_rd_ff | (8'd1 << low_k);
                  free_cnt_in = free_cnt_ff - CNT_W'(1);
                  stat_in     = STAT_OK;
                  pg_addr_in  = ADDR_W'({rd_idx_ff, low_k}) << PAGE_SHIFT;
                  stop_in     = 1'b1;
                  rd_vld_in   = 1'b0;
               end
            end
            ACT_FREE: begin
               stop_in   = 1'b1;
               rd_vld_in = 1'b0;
               if ((map_rd_ff & in_mask) == '0) begin
                  stat_in = STAT_DOUBLE_FREE;
               end else begin
                  wr_en       = 1'b1;
                  wr_data     = map_rd_ff & ~in_mask;
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
               end
            end
            ACT_MARK_USED: begin
               wr_en   = 1'b1;
               wr_data = map_rd_ff | in_mask;
               // count floor at zero
               if (free_cnt_ff >= CNT_W'(chg_n)) free_cnt_in = free_cnt_ff - CNT_W'(chg_n);
               else                              free_cnt_in = '0;
            end
            default: begin
               wr_en       = 1'b1;
               wr_data     = map_rd_ff & ~in_mask;
               free_cnt_in = free_cnt_ff + CNT_W'(chg_n);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      map_rd_ff <= map_mem[ptr_ff[MAP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff  <= CNT_W'(MAX_PAGES);
         free_cnt_ff <= '0;
         ptr_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         stop_ff     <= 1'b0;
      end else begin
         managed_ff  <= managed_in;
         free_cnt_ff <= free_cnt_in;
         ptr_ff      <= ptr_in;
         rd_vld_ff   <= rd_vld_in;
         stop_ff     <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff    <= action_type'(action);
         addr_ff   <= address;
         end_pg_ff <= END_W'(((LEN_W+2)'(address) + (LEN_W+2)'(range_bytes)
                              + (LEN_W+2)'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
      end
      limit_ff   <= limit_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rd_idx_ff  <= rd_idx_in;
      stat_ff    <= stat_in;
      pg_addr_ff <= pg_addr_in;
   end

   assign stat.clear_last = (ptr_ff == PTR_W'(MAP_DEPTH - 1));
   assign stat.walk_done  = stop_ff || (!rd_vld_ff && (ptr_ff >= limit_ff));

   assign status       = stat_ff;
   assign page_address = pg_addr_ff;
   assign free_total   = free_cnt_ff;

endmodule

[rtl/bitmap_page_allocator.sv]
// Bitmap first-fit page allocator.
// Request channel (req_*): one word per action, kind in req_tuser: allocate,
// free one page, mark a byte range used, mark a byte range free.
// Response channel (rsp_*): exactly one word per request: status in rsp_tuser,
// allocated page address and the free page count in rsp_tdata.
// csr_wr_en/csr_wr_data set the managed page count; write only while idle.
// One request at a time: taken in the idle state, then a setup state, then a
// walk over the page map, one map byte (eight pages) per cycle through the map
// RAM (one read port, one write port), then the response state. Map bytes
// walked per request:
//   allocate      : map bytes scanned, up to the first one with a free page
//   free          : one; none for an ignored, unaligned or out-of-range free
//   range marking : map bytes covered by the range, none if the range is empty
// After the response is taken the block returns to idle for the next request.
// Reset: all pages used, free count zero, managed pages 65536. The map RAM
// is then filled with ones, with req_tready low throughout (csr writes are
// still taken).
// A stalled response holds rsp_tvalid and its word; no request is taken
// until the response has gone.
module bitmap_page_allocator
   import bpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] address, [64:32] range_bytes, rest 0
   input  logic [ACT_W-1:0]      req_tuser,  // [1:0] action
   // response
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] page_address, [48:32] free_total, rest 0
   output logic [STAT_W-1:0]     rsp_tuser,  // [2:0] status
   // config
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data // managed_pages
);

   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic [ADDR_W-1:0] page_address;
   logic [CNT_W-1:0]  free_total;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpa_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .action       (req_tuser),
      .address      (req_tdata[ADDR_W-1:0]),
      .range_bytes  (req_tdata[ADDR_W+LEN_W-1:ADDR_W]),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .status       (rsp_tuser),
      .page_address (page_address),
      .free_total   (free_total)
   );

   // pad bits of req_tdata above range_bytes are ignored
   assign rsp_tdata = {(RSP_DATA_W-ADDR_W-CNT_W)'(0), free_total, page_address};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import bpa_pkg::*;

   // one request word as the sender sees it
   typedef struct {
      action_type          act;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
   } page_req_type;

   // one response word as the receiver should see it
   typedef struct {
      status_type          st;
      logic [ADDR_W-1:0]   page_addr;
      logic [CNT_W-1:0]    free_total;
   } page_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   // words waiting to be offered, and responses owed by the block, oldest first
   page_req_type queued_requests[$];
   page_rsp_type due_responses[$];

   // shadow of the allocator: page bits (1 = used), free count, page count register
   bit [MAX_PAGES-1:0] page_busy;
   int unsigned        shadow_free;
   int unsigned        cfg_pages;

   int  fail_count = 0;
   int  src_idle_pct = 0;
   int  snk_stall_pct = 0;
   int  hold_request = 0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;

   bitmap_page_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Next state of the pool for one request word, and the response it earns.
   function automatic page_rsp_type page_pool_step(page_req_type rq);
      page_rsp_type    res;
      longint unsigned top;
      longint unsigned pg;
      longint unsigned last;
      longint unsigned base;
      res.st = STAT_OK;
      res.page_addr = '0;
      // a page count above the map size behaves as the full map
      top = (cfg_pages > MAX_PAGES) ? MAX_PAGES : cfg_pages;
      case (rq.act)
         ACT_ALLOC: begin
            if (shadow_free == 0) begin
               res.st = STAT_OUT_OF_MEM;
            end else begin
               // first fit; free pages above the managed count do not count here
               res.st = STAT_NONE_FOUND;
               for (pg = 0; pg < top; pg++) begin
                  if (!page_busy[pg]) begin
                     page_busy[pg] = 1'b1;
                     shadow_free--;
                     res.st = STAT_OK;
                     res.page_addr = ADDR_W'(pg * PAGE_BYTES);
                     break;
                  end
               end
            end
         end
         ACT_FREE: begin
            pg = rq.addr / PAGE_BYTES;
            if (rq.addr == '0 || rq.addr == '1) begin
               res.st = STAT_IGNORED;
            end else if (rq.addr % PAGE_BYTES != 0) begin
               res.st = STAT_UNALIGNED;
            end else if (pg >= top) begin
               res.st = STAT_OUT_OF_RANGE;
            end else if (!page_busy[pg]) begin
               res.st = STAT_DOUBLE_FREE;
            end else begin
               page_busy[pg] = 1'b0;
               shadow_free++;
            end
         end
         default: begin
            // range rounds outward to whole pages, clipped at the page count
            base = rq.addr;
            last = (base + rq.len + PAGE_BYTES - 1) / PAGE_BYTES;
            if (last > top) last = top;
            for (pg = base / PAGE_BYTES; pg < last; pg++) begin
               if (rq.act == ACT_MARK_USED) begin
                  if (!page_busy[pg]) begin
                     page_busy[pg] = 1'b1;
                     if (shadow_free > 0) shadow_free--;
                  end
               end else if (page_busy[pg]) begin
                  page_busy[pg] = 1'b0;
                  shadow_free++;
               end
            end
         end
      endcase
      res.free_total = CNT_W'(shadow_free);
      return res;
   endfunction

   // Random word shaped by the current page count: mostly page-aligned frees and
   // short ranges near the managed pages, plus some wild addresses and lengths.
   function automatic page_req_type random_request(int unsigned pages);
      page_req_type r;
      int unsigned  sel;
      int unsigned  span;
      span = ((pages > MAX_PAGES) ? MAX_PAGES : pages) + 4;
      r.addr = $urandom;
      r.len = {1'($urandom_range(0, 1)), 32'($urandom)};
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         r.act = ACT_ALLOC;
      end else if (sel < 60) begin
         r.act = ACT_FREE;
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            r.addr = ADDR_W'($urandom_range(0, span - 1)) << PAGE_SHIFT;
         end else if (sel < 78) begin
            r.addr = (ADDR_W'($urandom_range(0, span - 1)) << PAGE_SHIFT)
                     | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
         end else if (sel < 84) begin
            r.addr = ($urandom_range(0, 1) != 0) ? '1 : '0;
         end
      end else begin
         r.act = (sel < 80) ? ACT_MARK_USED : ACT_MARK_FREE;
         if ($urandom_range(0, 99) < 85) begin
            r.addr = ADDR_W'($urandom_range(0, span - 1)) << PAGE_SHIFT;
            if ($urandom_range(0, 2) == 0) r.addr |= ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
         end
         sel = $urandom_range(0, 99);
         if (sel < 60) r.len = LEN_W'($urandom_range(0, 8 * PAGE_BYTES));
         else if (sel < 80) r.len = LEN_W'($urandom_range(0, PAGE_BYTES - 1));
         else if (sel < 90) r.len = '0;
      end
      return r;
   endfunction

   task automatic offer(action_type a, logic [ADDR_W-1:0] ad, logic [LEN_W-1:0] ln);
      page_req_type r;
      r.act = a;
      r.addr = ad;
      r.len = ln;
      queued_requests.push_back(r);
   endtask

   task automatic queue_random(int n);
      repeat (n) queued_requests.push_back(random_request(cfg_pages));
   endtask

   // wait until every queued word is taken and answered, then let the block settle
   task automatic drain();
      while (queued_requests.size() != 0 || req_tvalid || due_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // block is idle here, so the shadow register can follow at once
   task automatic write_page_count(int unsigned v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(v);
      cfg_pages = v & ((1 << CNT_W) - 1);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(int src, int snk);
      src_idle_pct = src;
      snk_stall_pct = snk;
   endtask

   task automatic random_phase(int unsigned pages, int n, int src, int snk);
      write_page_count(pages);
      set_idling(src, snk);
      queue_random(n);
      drain();
   endtask

   // Sender: a new word goes out once the last one was taken (or none was
   // up), unless this cycle rolls an idle gap.
   always @(negedge clock) begin : sender
      page_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (queued_requests.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            nxt = queued_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.act;
            req_tdata <= REQ_DATA_W'({nxt.len, nxt.addr});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Receiver: random stalls, or a long hold-off counted down here
   always @(negedge clock) begin : receiver
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   // Both handshakes sampled at the rising edge: a taken request word is run
   // through the shadow, a taken response word is checked against the oldest
   // owed response.
   always @(posedge clock) begin : monitor
      page_req_type rq;
      page_rsp_type want;
      if (!reset && req_tvalid && req_tready) begin
         rq.act = action_type'(req_tuser);
         rq.addr = req_tdata[ADDR_W-1:0];
         rq.len = req_tdata[ADDR_W +: LEN_W];
         due_responses.push_back(page_pool_step(rq));
         req_taken = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_responses.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: response word with nothing owed: status %0d addr %h free %0d",
                        $realtime, rsp_tuser, rsp_tdata[ADDR_W-1:0], rsp_tdata[ADDR_W +: CNT_W]);
         end else begin
            want = due_responses.pop_front();
            if (rsp_tuser !== want.st || rsp_tdata[ADDR_W-1:0] !== want.page_addr
                || rsp_tdata[ADDR_W +: CNT_W] !== want.free_total) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: mismatch: status %0d/%0d addr %h/%h free %0d/%0d (exp/act)",
                           $realtime, want.st, rsp_tuser, want.page_addr,
                           rsp_tdata[ADDR_W-1:0], want.free_total,
                           rsp_tdata[ADDR_W +: CNT_W]);
            end
         end
      end
   end

   initial begin
      // after reset: every page used, nothing free, full page count
      page_busy = '1;
      shadow_free = 0;
      cfg_pages = MAX_PAGES;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, full page count from reset. The first words wait out the
      // map fill behind req_tready.
      set_idling(0, 0);
      offer(ACT_ALLOC, $urandom, '0);                        // empty pool
      offer(ACT_FREE, '0, '0);                               // null address
      offer(ACT_FREE, '1, '1);                               // all-ones address
      offer(ACT_FREE, 32'h0000_1001, '0);                    // unaligned
      offer(ACT_FREE, 32'h1000_0000, '0);                    // first page past the end
      offer(ACT_FREE, 32'h0000_1000, '0);                    // good free
      offer(ACT_FREE, 32'h0000_1000, '0);                    // double free
      offer(ACT_ALLOC, '0, '0);
      offer(ACT_MARK_FREE, 32'h0000_0FFF, 33'd2);            // rounds out to pages 0 and 1
      offer(ACT_MARK_FREE, 32'h0000_5000, '0);               // zero length
      offer(ACT_MARK_FREE, '0, 33'h1_FFFF_FFFF);             // whole map free
      offer(ACT_ALLOC, '1, '1);
      offer(ACT_MARK_USED, '0, 33'h1_0000_0000);             // whole map used
      offer(ACT_MARK_FREE, '1, 33'h1_FFFF_FFFF);             // starts past the end
      offer(ACT_MARK_FREE, 32'h0000_F000, 33'h0_0000_3000);  // pages 15..17
      drain();

      // lowered count: free pages above it stay counted but cannot be found
      write_page_count(8);
      offer(ACT_ALLOC, '0, '0);
      offer(ACT_FREE, 32'h0000_8000, '0);
      offer(ACT_FREE, 32'h0000_7000, '0);
      offer(ACT_ALLOC, '0, '0);
      offer(ACT_MARK_FREE, '0, 33'h1_FFFF_FFFF);
      drain();

      write_page_count(0);
      offer(ACT_ALLOC, '0, '0);
      offer(ACT_FREE, 32'h0000_1000, '0);
      drain();

      // oversized count behaves as the full map
      write_page_count((1 << CNT_W) - 1);
      offer(ACT_ALLOC, '0, '0);
      offer(ACT_MARK_USED, '0, 33'h1_FFFF_FFFF);
      drain();

      // random part, mostly small page counts so scans and walks stay short
      random_phase(64, 250, 0, 0);
      random_phase(8, 150, 45, 0);

      // long receiver hold-off while the sender keeps offering
      write_page_count(64);
      set_idling(0, 45);
      hold_request = 3000;
      queue_random(300);
      drain();

      random_phase(200, 300, 35, 35);
      random_phase(1000, 300, 0, 0);

      // sender stops half way until every owed response is in
      write_page_count(13);
      set_idling(35, 35);
      queue_random(75);
      drain();
      queue_random(75);
      drain();

      random_phase(0, 30, 45, 0);
      random_phase(MAX_PAGES, 25, 0, 45);
      random_phase((1 << CNT_W) - 1, 15, 35, 35);
      random_phase(333, 230, 45, 0);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && due_responses.size() == 0) begin
         $display("[bitmap_page_allocator] OK");
      end else begin
         $display("[bitmap_page_allocator] ERROR");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #500_000_000;
      $display("[bitmap_page_allocator] ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_dpath.sv
rtl/bitmap_page_allocator.sv
sim/tb_top.sv
